FILE: rtl/ial_pkg.sv
`default_nettype none

package ial_pkg;

   localparam int CAPACITY    = 64;
   localparam int ENTRY_WIDTH = 32;

   // Widths of the request and result fields.
   localparam int ACTION_W = 3;
   localparam int POS_W    = 6;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 7;

   // Memory index and live count widths.
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [ACTION_W-1:0] ACT_APPEND    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_DROP      = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_READ      = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_OVERWRITE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_INSERT    = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_ERASE     = 3'd5;

   typedef enum logic [1:0] {
      PLAN_DONE,
      PLAN_READ,
      PLAN_INSERT,
      PLAN_ERASE
   } plan_kind_type;

   typedef struct packed {
      logic                   ok;
      plan_kind_type          kind;
      logic                   wr_en;
      logic [IDX_W-1:0]       wr_addr;
      logic [ENTRY_WIDTH-1:0] wr_data;
      logic [IDX_W-1:0]       rd_addr;
      logic [CNT_W-1:0]       next_count;
   } plan_type;

endpackage

`default_nettype wire

FILE: rtl/ial_ram.sv
`default_nettype none

module ial_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/ial_decode.sv
`default_nettype none

module ial_decode (
   input  wire logic [ial_pkg::ACTION_W-1:0] req_action,
   input  wire logic [ial_pkg::POS_W-1:0]    req_position,
   input  wire logic [ial_pkg::VALUE_W-1:0]  req_write_value,
   input  wire logic [ial_pkg::CNT_W-1:0]    count,
   output      ial_pkg::plan_type            plan
);

   logic [ial_pkg::CMP_W-1:0] pos_ext;
   logic [ial_pkg::CMP_W-1:0] cnt_ext;
   logic                      pos_ok;
   logic                      full;

   always_comb begin
      pos_ext = ial_pkg::CMP_W'(req_position);
      cnt_ext = ial_pkg::CMP_W'(count);
      pos_ok  = pos_ext < cnt_ext;
      full    = count == ial_pkg::CNT_W'(ial_pkg::CAPACITY);

      plan.ok         = 1'b0;
      plan.kind       = ial_pkg::PLAN_DONE;
      plan.wr_en      = 1'b0;
      plan.wr_addr    = ial_pkg::IDX_W'(req_position);
      plan.wr_data    = ial_pkg::ENTRY_WIDTH'(req_write_value);
      plan.rd_addr    = ial_pkg::IDX_W'(req_position);
      plan.next_count = count;

      case (req_action)
         ial_pkg::ACT_APPEND: begin
            if (!full) begin
               plan.ok         = 1'b1;
               plan.wr_en      = 1'b1;
               plan.wr_addr    = ial_pkg::IDX_W'(count);
               plan.next_count = ial_pkg::CNT_W'(count + 1'b1);
            end
         end
         ial_pkg::ACT_DROP: begin
            if (count != '0) begin
               plan.ok         = 1'b1;
               plan.next_count = ial_pkg::CNT_W'(count - 1'b1);
            end
         end
         ial_pkg::ACT_READ: begin
            if (pos_ok) begin
               plan.ok   = 1'b1;
               plan.kind = ial_pkg::PLAN_READ;
            end
         end
         ial_pkg::ACT_OVERWRITE: begin
            if (pos_ok) begin
               plan.ok    = 1'b1;
               plan.wr_en = 1'b1;
            end
         end
         ial_pkg::ACT_INSERT: begin
            // The shift runs from the last entry down to the insert point.
            if (pos_ok && !full) begin
               plan.ok         = 1'b1;
               plan.kind       = ial_pkg::PLAN_INSERT;
               plan.rd_addr    = ial_pkg::IDX_W'(count - 1'b1);
               plan.next_count = ial_pkg::CNT_W'(count + 1'b1);
            end
         end
         ial_pkg::ACT_ERASE: begin
            if (pos_ok) begin
               plan.ok         = 1'b1;
               plan.next_count = ial_pkg::CNT_W'(count - 1'b1);
               // Erasing the last entry needs no shift.
               if (ial_pkg::CMP_W'(pos_ext + 1'b1) < cnt_ext) begin
                  plan.kind    = ial_pkg::PLAN_ERASE;
                  plan.rd_addr = ial_pkg::IDX_W'(req_position + 1'b1);
               end
            end
         end
         default: begin
            plan.ok = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/indexed_array_list_engine.sv
// Channel   Handshake                 Payload
// request   start && !busy            req_action, req_position, req_write_value
// result    rsp_valid (one cycle)     rsp_ok, rsp_read_value, rsp_entry_count
//
// Append, drop, overwrite and refused requests answer in the cycle after the
// accept with busy staying low, so they can follow each other every cycle.
// Read answers from ST_READ, after the registered memory read. Insert at p
// shifts the entries from p up and erase shifts those above p down, since
// the entry memory has one write port and moves one entry per cycle.
// Synchronous reset empties the list; no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module indexed_array_list_engine (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output      logic                            busy,
   input  wire logic [ial_pkg::ACTION_W-1:0]    req_action,
   input  wire logic [ial_pkg::POS_W-1:0]       req_position,
   input  wire logic [ial_pkg::VALUE_W-1:0]     req_write_value,
   output      logic                            rsp_valid,
   output      logic                            rsp_ok,
   output      logic [ial_pkg::VALUE_W-1:0]     rsp_read_value,
   output      logic [ial_pkg::COUNT_W-1:0]     rsp_entry_count
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_INS_SHIFT,
      ST_INS_LAST,
      ST_ERA_SHIFT
   } state_type;

   state_type                           state_ff, state_in;
   logic [ial_pkg::CNT_W-1:0]           count_ff, count_in;
   logic [ial_pkg::IDX_W-1:0]           rd_idx_ff, rd_idx_in;
   logic [ial_pkg::IDX_W-1:0]           pos_idx_ff, pos_idx_in;
   logic [ial_pkg::IDX_W-1:0]           last_idx_ff, last_idx_in;
   logic [ial_pkg::ENTRY_WIDTH-1:0]     val_ff, val_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_ok_ff, rsp_ok_in;
   logic [ial_pkg::VALUE_W-1:0]         rsp_read_value_ff, rsp_read_value_in;
   logic [ial_pkg::COUNT_W-1:0]         rsp_entry_count_ff, rsp_entry_count_in;

   ial_pkg::plan_type                   plan;
   logic                                mem_wr_en;
   logic [ial_pkg::IDX_W-1:0]           mem_wr_addr;
   logic [ial_pkg::ENTRY_WIDTH-1:0]     mem_wr_data;
   logic [ial_pkg::IDX_W-1:0]           mem_rd_addr;
   logic [ial_pkg::ENTRY_WIDTH-1:0]     mem_rd_data;

   ial_decode u_decode (
      .req_action      (req_action),
      .req_position    (req_position),
      .req_write_value (req_write_value),
      .count           (count_ff),
      .plan            (plan)
   );

   ial_ram #(
      .WIDTH (ial_pkg::ENTRY_WIDTH),
      .DEPTH (ial_pkg::CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      state_in           = state_ff;
      count_in           = count_ff;
      rd_idx_in          = rd_idx_ff;
      pos_idx_in         = pos_idx_ff;
      last_idx_in        = last_idx_ff;
      val_in             = val_ff;
      rsp_valid_in       = 1'b0;
      rsp_ok_in          = rsp_ok_ff;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_entry_count_in = rsp_entry_count_ff;

      mem_wr_en   = 1'b0;
      mem_wr_addr = plan.wr_addr;
      mem_wr_data = plan.wr_data;
      mem_rd_addr = plan.rd_addr;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               count_in           = plan.next_count;
               rd_idx_in          = plan.rd_addr;
               pos_idx_in         = ial_pkg::IDX_W'(req_position);
               last_idx_in        = ial_pkg::IDX_W'(plan.next_count);
               val_in             = plan.wr_data;
               mem_wr_en          = plan.wr_en;
               rsp_ok_in          = plan.ok;
               rsp_read_value_in  = '0;
               rsp_entry_count_in = ial_pkg::COUNT_W'(plan.next_count);
               case (plan.kind)
                  ial_pkg::PLAN_READ:   state_in = ST_READ;
                  ial_pkg::PLAN_INSERT: state_in = ST_INS_SHIFT;
                  ial_pkg::PLAN_ERASE:  state_in = ST_ERA_SHIFT;
                  default:              rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in      = 1'b1;
            rsp_read_value_in = ial_pkg::VALUE_W'(mem_rd_data);
            state_in          = ST_IDLE;
         end
         ST_INS_SHIFT: begin
            // Each entry moves up one place; the next read is always below the
            // address being written, so no entry is read after it was moved.
            mem_wr_en   = 1'b1;
            mem_wr_addr = ial_pkg::IDX_W'(rd_idx_ff + 1'b1);
            mem_wr_data = mem_rd_data;
            if (rd_idx_ff == pos_idx_ff) begin
               state_in = ST_INS_LAST;
            end else begin
               mem_rd_addr = ial_pkg::IDX_W'(rd_idx_ff - 1'b1);
               rd_idx_in   = ial_pkg::IDX_W'(rd_idx_ff - 1'b1);
            end
         end
         ST_INS_LAST: begin
            mem_wr_en    = 1'b1;
            mem_wr_addr  = pos_idx_ff;
            mem_wr_data  = val_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_ERA_SHIFT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ial_pkg::IDX_W'(rd_idx_ff - 1'b1);
            mem_wr_data = mem_rd_data;
            if (rd_idx_ff == last_idx_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               mem_rd_addr = ial_pkg::IDX_W'(rd_idx_ff + 1'b1);
               rd_idx_in   = ial_pkg::IDX_W'(rd_idx_ff + 1'b1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff          <= rd_idx_in;
      pos_idx_ff         <= pos_idx_in;
      last_idx_ff        <= last_idx_in;
      val_ff             <= val_in;
      rsp_ok_ff          <= rsp_ok_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
   end

   assign busy            = state_ff != ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ial_pkg::CNT_W'(ial_pkg::CAPACITY))
      else $error("live count above capacity");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(start) && !$past(busy)) || $past(busy))
      else $error("result without a pending item");

   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !mem_wr_en)
      else $error("memory written during a read");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_read_value == '0)
      else $error("refused item returned data");

endmodule

`default_nettype wire

FILE: tb/indexed_array_list_engine_tb.sv
module indexed_array_list_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Action codes 6 and 7 have no meaning and must be refused.
   localparam logic [ial_pkg::ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ial_pkg::ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

   localparam int RANDOM_ITEMS  = 2000;
   localparam int PHASE_ITEMS   = 150;
   localparam int SETTLE_CYCLES = 100;
   localparam int MAX_REPORTS   = 10;

   typedef enum int {
      GROW_LIST,
      MIXED_LIST,
      SHRINK_LIST
   } list_phase_type;

   typedef struct packed {
      logic                        ok;
      logic [ial_pkg::VALUE_W-1:0] read_value;
      logic [ial_pkg::COUNT_W-1:0] entry_count;
   } list_reply_type;

   typedef struct {
      logic [ial_pkg::ACTION_W-1:0] action;
      logic [ial_pkg::POS_W-1:0]    position;
      logic [ial_pkg::VALUE_W-1:0]  write_value;
      bit                           typed;
      list_reply_type               reply;
   } list_request_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic [ial_pkg::ACTION_W-1:0] req_action = '0;
   logic [ial_pkg::POS_W-1:0]    req_position = '0;
   logic [ial_pkg::VALUE_W-1:0]  req_write_value = '0;
   logic                         busy;
   logic                         rsp_valid;
   logic                         rsp_ok;
   logic [ial_pkg::VALUE_W-1:0]  rsp_read_value;
   logic [ial_pkg::COUNT_W-1:0]  rsp_entry_count;

   logic [ial_pkg::ENTRY_WIDTH-1:0] shadow_entries [ial_pkg::CAPACITY];
   int                              shadow_count = 0;
   list_reply_type                  pending_replies [$];
   int                              failures = 0;
   bit                              idle_enabled = 1'b1;

   indexed_array_list_engine dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_position    (req_position),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_ok          (rsp_ok),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   // Applies one action to the shadow list and returns the reply it earns.
   function automatic list_reply_type apply_list_action(
      input logic [ial_pkg::ACTION_W-1:0] act,
      input logic [ial_pkg::POS_W-1:0]    pos,
      input logic [ial_pkg::VALUE_W-1:0]  val);
      list_reply_type r;
      int             idx;
      r = '0;
      case (act)
         ial_pkg::ACT_APPEND: begin
            if (shadow_count < ial_pkg::CAPACITY) begin
               shadow_entries[shadow_count] = val[ial_pkg::ENTRY_WIDTH-1:0];
               shadow_count++;
               r.ok = 1'b1;
            end
         end
         ial_pkg::ACT_DROP: begin
            if (shadow_count > 0) begin
               shadow_count--;
               r.ok = 1'b1;
            end
         end
         ial_pkg::ACT_READ: begin
            if (int'(pos) < shadow_count) begin
               r.read_value = ial_pkg::VALUE_W'(shadow_entries[pos]);
               r.ok = 1'b1;
            end
         end
         ial_pkg::ACT_OVERWRITE: begin
            if (int'(pos) < shadow_count) begin
               shadow_entries[pos] = val[ial_pkg::ENTRY_WIDTH-1:0];
               r.ok = 1'b1;
            end
         end
         ial_pkg::ACT_INSERT: begin
            if (int'(pos) < shadow_count && shadow_count < ial_pkg::CAPACITY) begin
               for (idx = shadow_count; idx > int'(pos); idx--) begin
                  shadow_entries[idx] = shadow_entries[idx-1];
               end
               shadow_entries[pos] = val[ial_pkg::ENTRY_WIDTH-1:0];
               shadow_count++;
               r.ok = 1'b1;
            end
         end
         ial_pkg::ACT_ERASE: begin
            if (int'(pos) < shadow_count) begin
               for (idx = int'(pos); idx + 1 < shadow_count; idx++) begin
                  shadow_entries[idx] = shadow_entries[idx+1];
               end
               shadow_count--;
               r.ok = 1'b1;
            end
         end
         default: ;
      endcase
      r.entry_count = ial_pkg::COUNT_W'(shadow_count);
      return r;
   endfunction

   function automatic list_request_type make_request(
      input logic [ial_pkg::ACTION_W-1:0] act,
      input logic [ial_pkg::POS_W-1:0]    pos,
      input logic [ial_pkg::VALUE_W-1:0]  val,
      input bit                           typed,
      input logic                         ok,
      input logic [ial_pkg::VALUE_W-1:0]  rd,
      input logic [ial_pkg::COUNT_W-1:0]  cnt);
      list_request_type req;
      req.action             = act;
      req.position           = pos;
      req.write_value        = val;
      req.typed              = typed;
      req.reply.ok           = ok;
      req.reply.read_value   = rd;
      req.reply.entry_count  = cnt;
      return req;
   endfunction

   // Grow phases favor appends and inserts so the list fills up, shrink phases
   // favor drops and erases so it empties; most positions hit a live entry.
   function automatic list_request_type random_request(input list_phase_type phase);
      logic [ial_pkg::ACTION_W-1:0] act;
      logic [ial_pkg::POS_W-1:0]    pos;
      logic [ial_pkg::VALUE_W-1:0]  val;
      int                           roll;
      int                           a_lim, i_lim, r_lim, o_lim, e_lim, d_lim;
      case (phase)
         GROW_LIST: begin
            a_lim = 55; i_lim = 70; r_lim = 78; o_lim = 86; e_lim = 91; d_lim = 96;
         end
         SHRINK_LIST: begin
            a_lim = 10; i_lim = 20; r_lim = 35; o_lim = 45; e_lim = 70; d_lim = 96;
         end
         default: begin
            a_lim = 20; i_lim = 35; r_lim = 55; o_lim = 70; e_lim = 85; d_lim = 96;
         end
      endcase
      roll = $urandom_range(99);
      if (roll < a_lim) act = ial_pkg::ACT_APPEND;
      else if (roll < i_lim) act = ial_pkg::ACT_INSERT;
      else if (roll < r_lim) act = ial_pkg::ACT_READ;
      else if (roll < o_lim) act = ial_pkg::ACT_OVERWRITE;
      else if (roll < e_lim) act = ial_pkg::ACT_ERASE;
      else if (roll < d_lim) act = ial_pkg::ACT_DROP;
      else act = $urandom_range(1) ? ACT_SPARE_6 : ACT_SPARE_7;
      if (shadow_count > 0 && $urandom_range(99) < 85) begin
         pos = ial_pkg::POS_W'($urandom_range(shadow_count - 1));
      end else begin
         pos = ial_pkg::POS_W'($urandom_range(ial_pkg::CAPACITY - 1));
      end
      roll = $urandom_range(19);
      if (roll == 0) val = '0;
      else if (roll == 1) val = '1;
      else val = $urandom();
      return make_request(act, pos, val, 1'b0, 1'b0, '0, '0);
   endfunction

   // Presents one item, waits until it is taken and records what it should return.
   task automatic issue_request(input list_request_type req);
      list_reply_type predicted;
      while (idle_enabled && $urandom_range(99) < 24) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start           <= 1'b1;
      req_action      <= req.action;
      req_position    <= req.position;
      req_write_value <= req.write_value;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = apply_list_action(req.action, req.position, req.write_value);
      pending_replies.push_back(req.typed ? req.reply : predicted);
   endtask

   always @(posedge clock) begin : result_check
      list_reply_type want;
      if (!reset && rsp_valid) begin
         if (pending_replies.size() == 0) begin
            report_failure($sformatf("unexpected result: ok=%0b read=%h count=%0d",
                                     rsp_ok, rsp_read_value, rsp_entry_count));
         end else begin
            want = pending_replies.pop_front();
            if (rsp_ok !== want.ok || rsp_read_value !== want.read_value ||
                rsp_entry_count !== want.entry_count) begin
               report_failure($sformatf(
                  "mismatch: expected ok=%0b read=%h count=%0d, got ok=%0b read=%h count=%0d",
                  want.ok, want.read_value, want.entry_count,
                  rsp_ok, rsp_read_value, rsp_entry_count));
            end
         end
      end
   end

   initial begin : stimulus
      list_request_type directed [$];
      list_phase_type   phase;
      int               n;
      foreach (shadow_entries[i]) shadow_entries[i] = '0;

      // Everything refused on an empty list.
      directed.push_back(make_request(ial_pkg::ACT_READ,      6'd0, '0, 1'b1, 1'b0, '0, 7'd0));
      directed.push_back(make_request(ial_pkg::ACT_DROP,      6'd0, '0, 1'b1, 1'b0, '0, 7'd0));
      directed.push_back(make_request(ial_pkg::ACT_INSERT,    6'd0, 32'hDEAD_BEEF,
                                      1'b1, 1'b0, '0, 7'd0));
      directed.push_back(make_request(ial_pkg::ACT_ERASE,     6'd0, '0, 1'b1, 1'b0, '0, 7'd0));
      directed.push_back(make_request(ial_pkg::ACT_OVERWRITE, 6'd0, '1, 1'b1, 1'b0, '0, 7'd0));
      directed.push_back(make_request(ACT_SPARE_6,            6'd0, '0, 1'b1, 1'b0, '0, 7'd0));
      directed.push_back(make_request(ACT_SPARE_7,            '1,   '1, 1'b1, 1'b0, '0, 7'd0));
      // Extreme values in and out.
      directed.push_back(make_request(ial_pkg::ACT_APPEND,    6'd0, '1, 1'b1, 1'b1, '0, 7'd1));
      directed.push_back(make_request(ial_pkg::ACT_APPEND,    6'd0, '0, 1'b1, 1'b1, '0, 7'd2));
      directed.push_back(make_request(ial_pkg::ACT_READ,      6'd0, '0, 1'b1, 1'b1, '1, 7'd2));
      directed.push_back(make_request(ial_pkg::ACT_READ,      6'd1, '1, 1'b1, 1'b1, '0, 7'd2));
      directed.push_back(make_request(ial_pkg::ACT_READ,      '1,   '0, 1'b1, 1'b0, '0, 7'd2));
      directed.push_back(make_request(ial_pkg::ACT_OVERWRITE, 6'd1, 32'hA5A5_A5A5,
                                      1'b1, 1'b1, '0, 7'd2));
      directed.push_back(make_request(ial_pkg::ACT_INSERT,    6'd0, 32'h1234_5678,
                                      1'b1, 1'b1, '0, 7'd3));
      directed.push_back(make_request(ial_pkg::ACT_INSERT,    6'd2, 32'h5A5A_5A5A,
                                      1'b0, 1'b0, '0, '0));
      // Insert at the count is refused; append is the way to add at the end.
      directed.push_back(make_request(ial_pkg::ACT_INSERT,    6'd4, 32'h0F0F_0F0F,
                                      1'b1, 1'b0, '0, 7'd4));
      directed.push_back(make_request(ial_pkg::ACT_READ,      6'd2, '0, 1'b0, 1'b0, '0, '0));
      directed.push_back(make_request(ial_pkg::ACT_ERASE,     6'd0, '0, 1'b0, 1'b0, '0, '0));
      directed.push_back(make_request(ial_pkg::ACT_READ,      6'd0, '0, 1'b0, 1'b0, '0, '0));
      directed.push_back(make_request(ial_pkg::ACT_ERASE,     6'd2, '0, 1'b0, 1'b0, '0, '0));
      directed.push_back(make_request(ial_pkg::ACT_OVERWRITE, '1,   '1, 1'b1, 1'b0, '0, 7'd2));
      directed.push_back(make_request(ial_pkg::ACT_ERASE,     '1,   '0, 1'b1, 1'b0, '0, 7'd2));
      directed.push_back(make_request(ACT_SPARE_7,            6'd1, '1, 1'b0, 1'b0, '0, '0));
      directed.push_back(make_request(ial_pkg::ACT_DROP,      6'd0, '0, 1'b0, 1'b0, '0, '0));
      directed.push_back(make_request(ial_pkg::ACT_READ,      6'd0, '0, 1'b0, 1'b0, '0, '0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) issue_request(directed[i]);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         case ((n / PHASE_ITEMS) % 3)
            0:       phase = GROW_LIST;
            1:       phase = MIXED_LIST;
            default: phase = SHRINK_LIST;
         endcase
         idle_enabled = !(n >= 800 && n < 1100);
         issue_request(random_request(phase));
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (failures == 0 && pending_replies.size() == 0) begin
         $display("PASS indexed_array_list_engine");
      end else begin
         $display("FAIL indexed_array_list_engine");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("FAIL indexed_array_list_engine");
      $finish;
   end

endmodule

FILE: files.f
rtl/ial_pkg.sv
rtl/ial_ram.sv
rtl/ial_decode.sv
rtl/indexed_array_list_engine.sv
tb/indexed_array_list_engine_tb.sv
